/* hw/rtl/ffwl_pkg.sv */
// Constants and register indexes for the flat-field window/level unit.
package ffwl_pkg;

    localparam int PIXEL_BITS_DEF = 16;

    localparam int RAW_W   = 16;
    localparam int DARK_W  = 20;
    localparam int GAIN_W  = 16;
    localparam int OUT_W   = 16;
    localparam int REG_W   = 32;
    localparam int IN_W    = 56;
    localparam int INDEX_W = 8;

    localparam int DARK_FRAC  = 4;
    localparam int GAIN_FRAC  = 12;
    localparam int SCALE_FRAC = 16;

    localparam logic [INDEX_W-1:0] REG_WINDOW_MIN   = 8'd0;
    localparam logic [INDEX_W-1:0] REG_WINDOW_SCALE = 8'd1;

    localparam logic [REG_W-1:0] WINDOW_MIN_RST   = 32'h0000_0000;
    localparam logic [REG_W-1:0] WINDOW_SCALE_RST = 32'h0001_0000;

endpackage

/* hw/rtl/flat_field_window_level_unit.sv */
// Top level: six-stage flat-field, gain and window/level pixel pipeline.
//
//  port group   dir   word contents
//  s_axis_*     in    raw_pixel, dark_value, gain_value
//  m_axis_*     out   out_pixel
//  cfg_*        in    register index, 32-bit write data
//
// One pixel per clock sustained while m_axis_tready stays high; there are six register
// stages: offset round, gain multiply, gain round and clamp, window subtract,
// 32x32 window multiply, and scale shift with clamp into the output register.
// Reset (rst_n low) empties every stage and loads window_min = 0, window_scale = 1.0.
// A stalled output holds its word; each stage takes a new word when it is empty or
// when the stage after it moves, so bubbles close up and nothing is lost or repeated.
module flat_field_window_level_unit #(
    parameter int PIXEL_BITS = ffwl_pkg::PIXEL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // raw_pixel [15:0], dark_value [35:16], gain_value [51:36], zero [55:52]
    input  logic [ffwl_pkg::IN_W-1:0]     s_axis_tdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // out_pixel [15:0]
    output logic [ffwl_pkg::OUT_W-1:0]    m_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ffwl_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [ffwl_pkg::REG_W-1:0]    cfg_data
);

    localparam int PB        = PIXEL_BITS;
    localparam int PMAX_INT  = (1 << PB) - 1;
    localparam int DIFF_W    = ffwl_pkg::DARK_W + 1;
    localparam int GPROD_W   = PB + ffwl_pkg::GAIN_W;
    localparam int RSUM_W    = PB + 5;
    localparam int WD_W      = ffwl_pkg::REG_W + 2;
    localparam int WPROD_W   = 2 * ffwl_pkg::REG_W;
    localparam int HI_W      = WPROD_W - ffwl_pkg::SCALE_FRAC;

    // configuration registers
    logic signed [ffwl_pkg::REG_W-1:0] window_min_reg;
    logic        [ffwl_pkg::REG_W-1:0] window_scale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_min_reg   <= ffwl_pkg::WINDOW_MIN_RST;
            window_scale_reg <= ffwl_pkg::WINDOW_SCALE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ffwl_pkg::REG_WINDOW_MIN:   window_min_reg   <= cfg_data;
                ffwl_pkg::REG_WINDOW_SCALE: window_scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage valid bits and advance chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdyo;

    assign rdyo = !vo_reg || m_axis_tready;
    assign rdy5 = !v5_reg || rdyo;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_axis_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdyo) vo_reg <= v5_reg;
        end
    end

    // stage 1: dark subtraction, round to pixel units
    logic [PB-1:0]                 raw_pb;
    logic [ffwl_pkg::DARK_W-1:0]   dark_in;
    logic [ffwl_pkg::GAIN_W-1:0]   gain_in;
    logic [ffwl_pkg::DARK_W-1:0]   raw_q;
    logic [DIFF_W-1:0]             diff;
    logic [PB-1:0]                 off_q;
    logic [ffwl_pkg::DARK_FRAC-1:0] off_r;
    logic                          off_inc;
    logic [PB-1:0]                 p1_next;
    logic [PB-1:0]                 p1_reg;
    logic [ffwl_pkg::GAIN_W-1:0]   gain1_reg;

    assign raw_pb  = s_axis_tdata[PB-1:0];
    assign dark_in = s_axis_tdata[35:16];
    assign gain_in = s_axis_tdata[51:36];
    assign raw_q   = ffwl_pkg::DARK_W'({raw_pb, 4'b0000});
    assign diff    = DIFF_W'(raw_q) - DIFF_W'(dark_in);
    assign off_q   = diff[PB+ffwl_pkg::DARK_FRAC-1:ffwl_pkg::DARK_FRAC];
    assign off_r   = diff[ffwl_pkg::DARK_FRAC-1:0];
    assign off_inc = (off_r > 4'b1000) || (off_r == 4'b1000 && off_q[0]);

    always_comb
    begin
        if (diff[DIFF_W-1] || diff == '0)
            p1_next = '0;
        else
            p1_next = off_q + PB'(off_inc);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && s_axis_tvalid)
        begin
            p1_reg    <= p1_next;
            gain1_reg <= gain_in;
        end
    end

    // stage 2: gain multiply
    logic [GPROD_W-1:0] gprod_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
            gprod_reg <= GPROD_W'(p1_reg) * GPROD_W'(gain1_reg);
    end

    // stage 3: round gain product, clamp to pixel range
    logic [PB+3:0]                   g_q;
    logic [ffwl_pkg::GAIN_FRAC-1:0]  g_r;
    logic                            g_inc;
    logic [RSUM_W-1:0]               g_sum;
    logic [PB-1:0]                   p2_next;
    logic [PB-1:0]                   p2_reg;

    assign g_q   = gprod_reg[GPROD_W-1:ffwl_pkg::GAIN_FRAC];
    assign g_r   = gprod_reg[ffwl_pkg::GAIN_FRAC-1:0];
    assign g_inc = (g_r > 12'h800) || (g_r == 12'h800 && g_q[0]);
    assign g_sum = RSUM_W'(g_q) + RSUM_W'(g_inc);

    always_comb
    begin
        if (g_sum > RSUM_W'(PMAX_INT))
            p2_next = PB'(PMAX_INT);
        else
            p2_next = g_sum[PB-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
            p2_reg <= p2_next;
    end

    // stage 4: window offset, zero when at or below the lower edge
    logic signed [WD_W-1:0]        p2_ext;
    logic signed [WD_W-1:0]        wm_ext;
    logic signed [WD_W-1:0]        wd;
    logic [ffwl_pkg::REG_W-1:0]    w_next;
    logic [ffwl_pkg::REG_W-1:0]    w_reg;

    assign p2_ext = WD_W'(p2_reg);
    assign wm_ext = {{2{window_min_reg[ffwl_pkg::REG_W-1]}}, window_min_reg};
    assign wd     = p2_ext - wm_ext;

    always_comb
    begin
        if (wd[WD_W-1] || wd == '0)
            w_next = '0;
        else
            w_next = wd[ffwl_pkg::REG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
            w_reg <= w_next;
    end

    // stage 5: window scale multiply
    logic [WPROD_W-1:0] wprod_reg;

    always_ff @(posedge clk)
    begin
        if (rdy5 && v4_reg)
            wprod_reg <= WPROD_W'(w_reg) * WPROD_W'(window_scale_reg);
    end

    // stage 6: drop scale fraction, saturate
    logic [HI_W-1:0]               hi;
    logic [PB-1:0]                 res_pb;
    logic [ffwl_pkg::OUT_W-1:0]    out_reg;

    assign hi = wprod_reg[WPROD_W-1:ffwl_pkg::SCALE_FRAC];

    always_comb
    begin
        if (hi > HI_W'(PMAX_INT))
            res_pb = PB'(PMAX_INT);
        else
            res_pb = hi[PB-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdyo && v5_reg)
            out_reg <= ffwl_pkg::OUT_W'(res_pb);
    end

    assign m_axis_tdata  = out_reg;
    assign m_axis_tvalid = vo_reg;

endmodule
